[hdl/dwcd_pkg.sv]
`default_nettype none
package dwcd_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 10;
  localparam int CFG_W               = 10;
  localparam int IDX_W               = 2;
  localparam int EV_W                = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW_TICKS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOGGLE_LIMIT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CRITICAL_TICKS = 2'd2;

  localparam logic [CFG_W-1:0] RST_WINDOW_TICKS   = 10'd40;
  localparam logic [CFG_W-1:0] RST_TOGGLE_LIMIT   = 10'd6;
  localparam logic [CFG_W-1:0] RST_CRITICAL_TICKS = 10'd37;

  localparam logic [EV_W-1:0] EV_LOW   = 2'd0;
  localparam logic [EV_W-1:0] EV_HIGH  = 2'd1;
  localparam logic [EV_W-1:0] EV_ALARM = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] window_ticks;
    logic [CFG_W-1:0] toggle_limit;
    logic [CFG_W-1:0] critical_ticks;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [EV_W-1:0] code;
  } res_t;

endpackage
`default_nettype wire

[hdl/dwcd_cfg.sv]
`default_nettype none
module dwcd_cfg (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wr_en,
  input  wire [dwcd_pkg::IDX_W-1:0]   wr_index,
  input  wire [dwcd_pkg::CFG_W-1:0]   wr_data,
  output dwcd_pkg::cfg_t              cfg
);
  import dwcd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks   <= RST_WINDOW_TICKS;
      cfg_r.toggle_limit   <= RST_TOGGLE_LIMIT;
      cfg_r.critical_ticks <= RST_CRITICAL_TICKS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WINDOW_TICKS:   cfg_r.window_ticks   <= wr_data;
        REG_TOGGLE_LIMIT:   cfg_r.toggle_limit   <= wr_data;
        REG_CRITICAL_TICKS: cfg_r.critical_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[hdl/dwcd_core.sv]
`default_nettype none
module dwcd_core #(
  parameter int COUNT_WIDTH = dwcd_pkg::DEFAULT_COUNT_WIDTH
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            fire,
  input  wire            sample,
  input  wire dwcd_pkg::cfg_t cfg,
  output dwcd_pkg::res_t res
);
  import dwcd_pkg::*;

  localparam int CW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   stable_r, stable_nxt;
  logic                   in_win_r, in_win_nxt;
  logic                   cand_r, cand_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] tog_r, tog_nxt;

  logic [CW-1:0]          tick_x, tog_x, win_x, lim_x, crit_x;
  logic [CW:0]            tick_inc_x;
  logic [COUNT_WIDTH-1:0] tog_step;
  logic                   alarm, window_done;

  assign tick_x     = CW'(tick_r);
  assign tog_x      = CW'(tog_r);
  assign win_x      = CW'(cfg.window_ticks);
  assign lim_x      = CW'(cfg.toggle_limit);
  assign crit_x     = CW'(cfg.critical_ticks);
  assign tick_inc_x = {1'b0, tick_x} + {{CW{1'b0}}, 1'b1};

  assign alarm       = (tog_x >= lim_x) && (tick_x < crit_x);
  assign window_done = (tick_r == CNT_MAX) || (tick_inc_x >= {1'b0, win_x});
  assign tog_step    = ((sample != cand_r) && (tog_r != CNT_MAX)) ? tog_r + 1'b1 : tog_r;

  always_comb begin
    stable_nxt = stable_r;
    in_win_nxt = in_win_r;
    cand_nxt   = cand_r;
    tick_nxt   = tick_r;
    tog_nxt    = tog_r;
    res.valid  = 1'b0;
    res.code   = EV_LOW;
    if (!in_win_r) begin
      if (sample != stable_r) begin
        cand_nxt = sample;
        tick_nxt = '0;
        tog_nxt  = '0;
        if (cfg.window_ticks == '0) begin
          stable_nxt = sample;
          res.valid  = 1'b1;
          res.code   = sample ? EV_HIGH : EV_LOW;
        end else begin
          in_win_nxt = 1'b1;
        end
      end
    end else if (alarm) begin
      in_win_nxt = 1'b0;
      tick_nxt   = '0;
      tog_nxt    = '0;
      stable_nxt = sample;
      cand_nxt   = sample;
      res.valid  = 1'b1;
      res.code   = EV_ALARM;
    end else if (window_done) begin
      in_win_nxt = 1'b0;
      tick_nxt   = '0;
      tog_nxt    = '0;
      cand_nxt   = sample;
      if (sample != stable_r) begin
        stable_nxt = sample;
        res.valid  = 1'b1;
        res.code   = sample ? EV_HIGH : EV_LOW;
      end
    end else begin
      cand_nxt = sample;
      tog_nxt  = tog_step;
      tick_nxt = tick_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      in_win_r <= 1'b0;
      cand_r   <= 1'b0;
      tick_r   <= '0;
      tog_r    <= '0;
    end else if (fire) begin
      stable_r <= stable_nxt;
      in_win_r <= in_win_nxt;
      cand_r   <= cand_nxt;
      tick_r   <= tick_nxt;
      tog_r    <= tog_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/debounce_with_chatter_detect.sv]
// Sample and event words are registered; an event word loads when its sample advances.
// Throughput: one sample word per cycle; a waiting event word lets one more sample into the
// input register, after which the input stalls until the event word is taken.
// Samples that cause no event are consumed with no output word.
// Reset: synchronous active-low rst_n clears the pipeline, the debounce state and
// loads the default window, toggle limit and critical tick registers.
`default_nettype none
module debounce_with_chatter_detect #(
  parameter int COUNT_WIDTH = dwcd_pkg::DEFAULT_COUNT_WIDTH
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire [7:0]                 in_tdata,   // [0] sample_level, [7:1] zero
  output logic                      out_tvalid,
  input  wire                       out_tready,
  output logic [7:0]                out_tdata,  // [1:0] event_code, [7:2] zero
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [dwcd_pkg::IDX_W-1:0] cfg_index,
  input  wire [dwcd_pkg::CFG_W-1:0] cfg_data
);
  import dwcd_pkg::*;

  cfg_t            cfg;
  res_t            res;
  logic            s1_v_r;
  logic            s1_sample_r;
  logic            out_v_r;
  logic [EV_W-1:0] out_code_r;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  dwcd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dwcd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res.valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r <= res.code;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(8-EV_W){1'b0}}, out_code_r};

`ifndef SYNTHESIS
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("illegal event code");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled with free pipeline space");

  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid) |=> (out_v_r && out_code_r == $past(res.code)))
    else $error("event word not registered");
`endif

endmodule
`default_nettype wire

[verif/debounce_with_chatter_detect_tb.sv]
`timescale 1ns / 1ps
module debounce_with_chatter_detect_tb;
  import dwcd_pkg::*;

  localparam int                 CNT_W      = DEFAULT_COUNT_WIDTH;
  localparam logic [CNT_W-1:0]   COUNT_TOP  = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0]   REG_UNUSED = 2'd3;
  localparam int                 MAX_REPORT = 10;

  class event_scoreboard;
    logic [CFG_W-1:0] win_len;
    logic [CFG_W-1:0] chatter_lim;
    logic [CFG_W-1:0] crit_len;
    bit               stable;
    bit               in_win;
    bit               cand;
    logic [CNT_W-1:0] ticks;
    logic [CNT_W-1:0] toggles;
    logic [EV_W-1:0]  expected_events[$];
    int               errors;

    function new();
      win_len     = RST_WINDOW_TICKS;
      chatter_lim = RST_TOGGLE_LIMIT;
      crit_len    = RST_CRITICAL_TICKS;
      stable      = 1'b0;
      in_win      = 1'b0;
      cand        = 1'b0;
      ticks       = '0;
      toggles     = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WINDOW_TICKS:   win_len = val;
        REG_TOGGLE_LIMIT:   chatter_lim = val;
        REG_CRITICAL_TICKS: crit_len = val;
        default: ;
      endcase
    endfunction

    function void close_window();
      in_win  = 1'b0;
      toggles = '0;
      ticks   = '0;
      if (cand != stable) begin
        stable = cand;
        expected_events.push_back(stable ? EV_HIGH : EV_LOW);
      end
    endfunction

    // returns 0 when the word is dropped by an idle debouncer
    function bit note_sample(bit s);
      if (!in_win) begin
        if (s == stable) return 1'b0;
        in_win  = 1'b1;
        cand    = s;
        ticks   = '0;
        toggles = '0;
        if (win_len == '0) close_window();
        return 1'b1;
      end
      if (toggles >= chatter_lim && ticks < crit_len) begin
        in_win  = 1'b0;
        toggles = '0;
        ticks   = '0;
        stable  = s;
        cand    = s;
        expected_events.push_back(EV_ALARM);
        return 1'b1;
      end
      if (s != cand) begin
        if (toggles != COUNT_TOP) toggles++;
        cand = s;
      end
      if (ticks == COUNT_TOP) begin
        close_window();
        return 1'b1;
      end
      ticks++;
      if (ticks >= win_len) close_window();
      return 1'b1;
    endfunction

    function void check_event(logic [7:0] word);
      logic [EV_W-1:0] exp_code;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("unexpected event word: got code %0d", word[EV_W-1:0]);
        return;
      end
      exp_code = expected_events.pop_front();
      if (word[EV_W-1:0] !== exp_code) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("event code mismatch: expected %0d, got %0d", exp_code, word[EV_W-1:0]);
      end
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'd0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0] cfg_data   = '0;

  event_scoreboard sb;
  bit              calm      = 1'b0;
  int              hold_req  = 0;
  int              hold_left = 0;

  debounce_with_chatter_detect u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_event(out_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic send_sample(input bit s);
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(sb.note_sample(s));
  endtask

  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_sample(bits[i]);
  endtask

  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] lim,
                                input logic [CFG_W-1:0] crit);
    write_reg(REG_WINDOW_TICKS, win);
    write_reg(REG_TOGGLE_LIMIT, lim);
    write_reg(REG_CRITICAL_TICKS, crit);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_alternating(input int count);
    bit lvl;
    lvl = sb.stable;
    for (int i = 0; i < count; i++) begin
      lvl = ~lvl;
      send_sample(lvl);
    end
  endtask

  task automatic run_phase(input int count);
    int  done;
    int  len;
    int  cap;
    bit  lvl;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len && done < count; i++) begin
          send_sample(1'($urandom_range(1)));
          done++;
        end
      end else begin
        lvl = 1'($urandom_range(1));
        len = $urandom_range(0, 10);
        for (int i = 0; i < len && done < count; i++) begin
          send_sample(1'($urandom_range(1)));
          done++;
        end
        cap = (sb.win_len < 45) ? int'(sb.win_len) + 3 : 48;
        len = $urandom_range(1, cap);
        for (int i = 0; i < len && done < count; i++) begin
          send_sample(lvl);
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] win;
    logic [CFG_W-1:0] lim;
    logic [CFG_W-1:0] crit;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settle with and without change, then immediate settle on a zero window
    set_thresholds(10'd2, 10'd1023, 10'd0);
    send_bits(32'b100_111_000, 9);
    drain_events();
    set_thresholds(10'd0, 10'd6, 10'd37);
    send_bits(32'b100, 3);
    drain_events();
    // zero limit trips on the first tick, then a counted burst trips it
    set_thresholds(10'd5, 10'd0, 10'd1);
    send_bits(32'b1011, 4);
    drain_events();
    set_thresholds(10'd1023, 10'd2, 10'd1023);
    write_reg(REG_UNUSED, 10'd1023);
    cfg_valid <= 1'b0;
    send_bits(32'b0101, 4);
    drain_events();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin win = RST_WINDOW_TICKS; lim = RST_TOGGLE_LIMIT; crit = RST_CRITICAL_TICKS; end
        1: begin win = 10'd0;    lim = 10'd0;    crit = 10'd0;    end
        2: begin win = 10'd1;    lim = 10'd0;    crit = 10'd1023; end
        3: begin win = 10'd1023; lim = 10'd1023; crit = 10'd1023; end
        4: begin win = 10'd3;    lim = 10'd1;    crit = 10'd2;    end
        5: begin win = 10'd1023; lim = 10'd0;    crit = 10'd0;    end
        default: begin
          win  = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, 1023))
                                          : CFG_W'($urandom_range(1, 24));
          lim  = CFG_W'($urandom_range(0, 8));
          crit = CFG_W'($urandom_range(0, 30));
        end
      endcase
      calm = (p == 3);
      set_thresholds(win, lim, crit);
      if (p == 1) begin
        run_alternating(40);
        hold_req = 300;
        run_alternating(90);
      end else begin
        run_phase(130);
      end
      drain_events();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (sb.expected_events.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
